// File: rtl/tcc_pkg.sv
// shared constants for the triangle circumcircle core
`timescale 1ns / 1ps
package tcc_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int TAG_W          = 16;
    localparam int CTR_W          = 32;
    localparam int RAD_W          = 32;
    localparam int GC_W           = 16;
    localparam int SQRT_IN_W      = 64;
    localparam int WIDE_W         = 64;

    localparam logic signed [CTR_W-1:0] CTR_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [CTR_W-1:0] CTR_MIN = 32'sh8000_0000;
    localparam logic [RAD_W-1:0]        RAD_MAX = 32'hFFFF_FFFF;
    localparam logic signed [31:0]      GC_MAX  = 32'sd32767;
    localparam logic signed [31:0]      GC_MIN  = -32'sd32768;

endpackage

// File: rtl/tcc_if.sv
// valid/ready channel interfaces for triangle items and circumcircle results
`timescale 1ns / 1ps
interface tcc_in_if #(parameter int COORD_BITS = tcc_pkg::COORD_BITS_DEF);
    import tcc_pkg::*;
    logic                         valid;
    logic                         ready;
    logic [TAG_W-1:0]             triangle_tag;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    modport source (output valid, triangle_tag, ax, ay, bx, by_coord, cx, cy, input ready);
    modport sink (input valid, triangle_tag, ax, ay, bx, by_coord, cx, cy, output ready);
endinterface

interface tcc_out_if;
    import tcc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [TAG_W-1:0]        tag_out;
    logic signed [CTR_W-1:0] center_x;
    logic signed [CTR_W-1:0] center_y;
    logic [RAD_W-1:0]        radius;
    logic signed [GC_W-1:0]  centroid_x;
    logic signed [GC_W-1:0]  centroid_y;
    logic                    degenerate;
    logic                    saturated;
    modport source (output valid, tag_out, center_x, center_y, radius, centroid_x,
                    centroid_y, degenerate, saturated, input ready);
    modport sink (input valid, tag_out, center_x, center_y, radius, centroid_x,
                  centroid_y, degenerate, saturated, output ready);
endinterface

// File: rtl/triangle_circumcircle_core.sv
// top level of the triangle circumcenter, circumradius and centroid pipeline
//
// tri_in takes one triangle (tag and three vertices) per transfer, res_out
// gives one result per triangle in the same order. Both are valid/ready.
// Throughput: one triangle per cycle while res_out is not stalled.
// From input transfer to res_out valid a triangle passes 7 stages of input
// register, products and differences, one stage per quotient bit in the
// rounding divider, 5 stages for the distance to vertex A, 32 stages of the
// square root and the output register. The divider depth follows the
// quotient width and is the largest single part of the pipeline depth.
// The whole pipeline advances together: while a result waits at res_out,
// tri_in.ready is low; bubbles do not hold anything back, a new triangle is
// taken whenever the output register is empty or being read.
// Collinear vertices give degenerate set and all numeric fields zero.
// Reset clears all valid bits; the pipeline is empty and ready afterwards.
`timescale 1ns / 1ps
module triangle_circumcircle_core #(
    parameter int COORD_BITS = tcc_pkg::COORD_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    tcc_in_if.sink    tri_in,
    tcc_out_if.source res_out
);
    import tcc_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int DFW  = CB + 1;
    localparam int SQW  = 2 * CB;
    localparam int NW   = 2 * CB + 1;
    localparam int NDW  = 2 * CB + 2;
    localparam int RPW  = 2 * CB + 2;
    localparam int RW   = 2 * CB + 3;
    localparam int PPW  = 3 * CB + 3;
    localparam int PW   = 3 * CB + 4;
    localparam int QW   = 3 * CB + 8;
    localparam int DVW  = 2 * CB + 4;
    localparam int SMW  = CB + 2;
    localparam int GN   = CB + 6;
    localparam int GS   = GN + 2;
    localparam int GPW  = GN + GS;
    localparam logic [GS-1:0] GMUL = GS'(((longint'(1) << GS) + 2) / 3);

    typedef struct packed {
        logic [TAG_W-1:0]       tag;
        logic signed [CB-1:0]   ax;
        logic signed [CB-1:0]   ay;
        logic signed [GC_W-1:0] gx;
        logic signed [GC_W-1:0] gy;
        logic                   degen;
        logic                   neg_x;
        logic                   neg_y;
    } div_side_t;

    typedef struct packed {
        logic [TAG_W-1:0]        tag;
        logic signed [CTR_W-1:0] cx;
        logic signed [CTR_W-1:0] cy;
        logic signed [GC_W-1:0]  gx;
        logic signed [GC_W-1:0]  gy;
        logic                    degen;
        logic                    csat;
        logic                    rsat;
    } sqrt_side_t;

    logic en;
    logic out_v_reg;

    assign en          = !out_v_reg || res_out.ready;
    assign tri_in.ready = en;

    // stage 1: input register
    logic                 v1_reg;
    logic [TAG_W-1:0]     tag1_reg;
    logic signed [CB-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg, cx1_reg, cy1_reg;

    // stage 2: edge vectors, squares, vertex sums
    logic                  v2_reg;
    logic [TAG_W-1:0]      tag2_reg;
    logic signed [CB-1:0]  ax2_reg, ay2_reg;
    logic signed [DFW-1:0] dbx2_reg, dby2_reg, dcx2_reg, dcy2_reg;
    logic signed [SQW-1:0] sqax2_reg, sqay2_reg, sqbx2_reg, sqby2_reg, sqcx2_reg, sqcy2_reg;
    logic signed [SMW-1:0] smx2_reg, smy2_reg;

    // stage 3: squared norms, centroid magnitude
    logic                  v3_reg;
    logic [TAG_W-1:0]      tag3_reg;
    logic signed [CB-1:0]  ax3_reg, ay3_reg;
    logic signed [DFW-1:0] dbx3_reg, dby3_reg, dcx3_reg, dcy3_reg;
    logic signed [NW-1:0]  na3_reg, nb3_reg, nc3_reg;
    logic [GN-1:0]         gmx3_reg, gmy3_reg;
    logic                  gnx3_reg, gny3_reg;
    logic [SMW-1:0]        smx_abs, smy_abs;

    // stage 4: norm differences, orientation products, reciprocal product
    logic                  v4_reg;
    logic [TAG_W-1:0]      tag4_reg;
    logic signed [CB-1:0]  ax4_reg, ay4_reg;
    logic signed [DFW-1:0] dbx4_reg, dby4_reg, dcx4_reg, dcy4_reg;
    logic signed [NDW-1:0] nca4_reg, nba4_reg;
    logic signed [RPW-1:0] r1_4_reg, r2_4_reg;
    logic [GPW-1:0]        gpx4_reg, gpy4_reg;
    logic                  gnx4_reg, gny4_reg;

    // stage 5: lifted products, orientation, centroid
    logic                   v5_reg;
    logic [TAG_W-1:0]       tag5_reg;
    logic signed [CB-1:0]   ax5_reg, ay5_reg;
    logic signed [PPW-1:0]  p1_5_reg, p2_5_reg, q1_5_reg, q2_5_reg;
    logic signed [RW-1:0]   r5_reg;
    logic signed [GC_W-1:0] gx5_reg, gy5_reg;
    logic signed [GC_W-1:0] gx5_next, gy5_next;

    // stage 6: determinants
    logic                   v6_reg;
    logic [TAG_W-1:0]       tag6_reg;
    logic signed [CB-1:0]   ax6_reg, ay6_reg;
    logic signed [PW-1:0]   p6_reg, q6_reg;
    logic signed [RW-1:0]   r6_reg;
    logic signed [GC_W-1:0] gx6_reg, gy6_reg;

    // stage 7: divider operands
    logic           v7_reg;
    logic [QW-1:0]  mx7_reg, my7_reg;
    logic [DVW-1:0] den7_reg;
    div_side_t      side7_reg;
    logic [PW-1:0]  pmag, qmag;
    logic [RW-1:0]  rmag;

    // divider
    logic      dv_valid;
    logic [QW-1:0] quo_x, quo_y;
    div_side_t dv_side;

    // stage 8: signed center
    logic                     v8_reg;
    logic signed [WIDE_W-1:0] ux8_reg, uy8_reg;
    div_side_t                side8_reg;

    // stage 9: offset to vertex A, clipped center
    logic                     v9_reg;
    logic signed [WIDE_W-1:0] dx9_reg, dy9_reg;
    logic signed [CTR_W-1:0]  cx9_reg, cy9_reg;
    logic                     csat9_reg;
    div_side_t                side9_reg;
    logic signed [CTR_W-1:0]  cx9_next, cy9_next;
    logic                     csat9_next;

    // stage 10: magnitudes
    logic              v10_reg;
    logic [WIDE_W-1:0] ex10_reg, ey10_reg;
    sqrt_side_t        side10_reg;

    // stage 11: squares
    logic              v11_reg;
    logic [WIDE_W-1:0] sqx11_reg, sqy11_reg;
    logic              big11_reg;
    sqrt_side_t        side11_reg;

    // stage 12: squared distance
    logic                 v12_reg;
    logic [SQRT_IN_W-1:0] d12_reg;
    sqrt_side_t           side12_reg;
    logic [SQRT_IN_W:0]   dsum;

    // square root
    logic              sq_valid;
    logic [RAD_W-1:0]  sq_root;
    sqrt_side_t        sq_side;

    // output register
    logic [TAG_W-1:0]        tag_o_reg;
    logic signed [CTR_W-1:0] cx_o_reg, cy_o_reg;
    logic [RAD_W-1:0]        rad_o_reg;
    logic signed [GC_W-1:0]  gx_o_reg, gy_o_reg;
    logic                    degen_o_reg, sat_o_reg;

    always_comb
    begin
        smx_abs = (smx2_reg < 0) ? SMW'(-smx2_reg) : SMW'(smx2_reg);
        smy_abs = (smy2_reg < 0) ? SMW'(-smy2_reg) : SMW'(smy2_reg);
    end

    function automatic logic signed [GC_W-1:0] centroid_clip(logic [GPW-1:0] prod, logic neg);
        logic [GN-1:0]     quo;
        logic signed [31:0] val;
        quo = prod[GPW-1:GS];
        val = neg ? -$signed(32'(quo)) : $signed(32'(quo));
        if (val > GC_MAX)
            return GC_MAX[GC_W-1:0];
        else if (val < GC_MIN)
            return GC_MIN[GC_W-1:0];
        else
            return val[GC_W-1:0];
    endfunction

    always_comb
    begin
        gx5_next = centroid_clip(gpx4_reg, gnx4_reg);
        gy5_next = centroid_clip(gpy4_reg, gny4_reg);
    end

    always_comb
    begin
        pmag = (p6_reg < 0) ? PW'(-p6_reg) : PW'(p6_reg);
        qmag = (q6_reg < 0) ? PW'(-q6_reg) : PW'(q6_reg);
        rmag = (r6_reg < 0) ? RW'(-r6_reg) : RW'(r6_reg);
    end

    always_comb
    begin
        cx9_next   = ux8_reg[CTR_W-1:0];
        cy9_next   = uy8_reg[CTR_W-1:0];
        csat9_next = 1'b0;
        if (ux8_reg > WIDE_W'(CTR_MAX))
        begin
            cx9_next   = CTR_MAX;
            csat9_next = 1'b1;
        end
        else if (ux8_reg < WIDE_W'(CTR_MIN))
        begin
            cx9_next   = CTR_MIN;
            csat9_next = 1'b1;
        end
        if (uy8_reg > WIDE_W'(CTR_MAX))
        begin
            cy9_next   = CTR_MAX;
            csat9_next = 1'b1;
        end
        else if (uy8_reg < WIDE_W'(CTR_MIN))
        begin
            cy9_next   = CTR_MIN;
            csat9_next = 1'b1;
        end
    end

    assign dsum = (SQRT_IN_W + 1)'(sqx11_reg) + (SQRT_IN_W + 1)'(sqy11_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            v6_reg    <= 1'b0;
            v7_reg    <= 1'b0;
            v8_reg    <= 1'b0;
            v9_reg    <= 1'b0;
            v10_reg   <= 1'b0;
            v11_reg   <= 1'b0;
            v12_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= tri_in.valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
            v7_reg    <= v6_reg;
            v8_reg    <= dv_valid;
            v9_reg    <= v8_reg;
            v10_reg   <= v9_reg;
            v11_reg   <= v10_reg;
            v12_reg   <= v11_reg;
            out_v_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag1_reg <= tri_in.triangle_tag;
            ax1_reg  <= tri_in.ax;
            ay1_reg  <= tri_in.ay;
            bx1_reg  <= tri_in.bx;
            by1_reg  <= tri_in.by_coord;
            cx1_reg  <= tri_in.cx;
            cy1_reg  <= tri_in.cy;

            tag2_reg  <= tag1_reg;
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            dbx2_reg  <= DFW'(bx1_reg) - DFW'(ax1_reg);
            dby2_reg  <= DFW'(by1_reg) - DFW'(ay1_reg);
            dcx2_reg  <= DFW'(cx1_reg) - DFW'(ax1_reg);
            dcy2_reg  <= DFW'(cy1_reg) - DFW'(ay1_reg);
            sqax2_reg <= SQW'(ax1_reg) * SQW'(ax1_reg);
            sqay2_reg <= SQW'(ay1_reg) * SQW'(ay1_reg);
            sqbx2_reg <= SQW'(bx1_reg) * SQW'(bx1_reg);
            sqby2_reg <= SQW'(by1_reg) * SQW'(by1_reg);
            sqcx2_reg <= SQW'(cx1_reg) * SQW'(cx1_reg);
            sqcy2_reg <= SQW'(cy1_reg) * SQW'(cy1_reg);
            smx2_reg  <= SMW'(ax1_reg) + SMW'(bx1_reg) + SMW'(cx1_reg);
            smy2_reg  <= SMW'(ay1_reg) + SMW'(by1_reg) + SMW'(cy1_reg);

            tag3_reg <= tag2_reg;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            dbx3_reg <= dbx2_reg;
            dby3_reg <= dby2_reg;
            dcx3_reg <= dcx2_reg;
            dcy3_reg <= dcy2_reg;
            na3_reg  <= NW'(sqax2_reg) + NW'(sqay2_reg);
            nb3_reg  <= NW'(sqbx2_reg) + NW'(sqby2_reg);
            nc3_reg  <= NW'(sqcx2_reg) + NW'(sqcy2_reg);
            gmx3_reg <= {smx_abs, 4'b0000};
            gmy3_reg <= {smy_abs, 4'b0000};
            gnx3_reg <= smx2_reg < 0;
            gny3_reg <= smy2_reg < 0;

            tag4_reg <= tag3_reg;
            ax4_reg  <= ax3_reg;
            ay4_reg  <= ay3_reg;
            dbx4_reg <= dbx3_reg;
            dby4_reg <= dby3_reg;
            dcx4_reg <= dcx3_reg;
            dcy4_reg <= dcy3_reg;
            nca4_reg <= NDW'(nc3_reg) - NDW'(na3_reg);
            nba4_reg <= NDW'(nb3_reg) - NDW'(na3_reg);
            r1_4_reg <= RPW'(dbx3_reg) * RPW'(dcy3_reg);
            r2_4_reg <= RPW'(dby3_reg) * RPW'(dcx3_reg);
            gpx4_reg <= GPW'(gmx3_reg) * GPW'(GMUL);
            gpy4_reg <= GPW'(gmy3_reg) * GPW'(GMUL);
            gnx4_reg <= gnx3_reg;
            gny4_reg <= gny3_reg;

            tag5_reg <= tag4_reg;
            ax5_reg  <= ax4_reg;
            ay5_reg  <= ay4_reg;
            p1_5_reg <= PPW'(dby4_reg) * PPW'(nca4_reg);
            p2_5_reg <= PPW'(nba4_reg) * PPW'(dcy4_reg);
            q1_5_reg <= PPW'(dbx4_reg) * PPW'(nca4_reg);
            q2_5_reg <= PPW'(nba4_reg) * PPW'(dcx4_reg);
            r5_reg   <= RW'(r1_4_reg) - RW'(r2_4_reg);
            gx5_reg  <= gx5_next;
            gy5_reg  <= gy5_next;

            tag6_reg <= tag5_reg;
            ax6_reg  <= ax5_reg;
            ay6_reg  <= ay5_reg;
            p6_reg   <= PW'(p1_5_reg) - PW'(p2_5_reg);
            q6_reg   <= PW'(q2_5_reg) - PW'(q1_5_reg);
            r6_reg   <= r5_reg;
            gx6_reg  <= gx5_reg;
            gy6_reg  <= gy5_reg;

            // |-8P| * 2 + |R| over 2|R| rounds half away from zero
            mx7_reg         <= {pmag, 4'b0000} + QW'(rmag);
            my7_reg         <= {qmag, 4'b0000} + QW'(rmag);
            den7_reg        <= {rmag, 1'b0};
            side7_reg.tag   <= tag6_reg;
            side7_reg.ax    <= ax6_reg;
            side7_reg.ay    <= ay6_reg;
            side7_reg.gx    <= gx6_reg;
            side7_reg.gy    <= gy6_reg;
            side7_reg.degen <= (r6_reg == 0);
            side7_reg.neg_x <= (p6_reg > 0) ^ (r6_reg < 0);
            side7_reg.neg_y <= (q6_reg > 0) ^ (r6_reg < 0);

            ux8_reg   <= dv_side.neg_x ? -$signed(WIDE_W'(quo_x)) : $signed(WIDE_W'(quo_x));
            uy8_reg   <= dv_side.neg_y ? -$signed(WIDE_W'(quo_y)) : $signed(WIDE_W'(quo_y));
            side8_reg <= dv_side;

            dx9_reg   <= ux8_reg - (WIDE_W'(side8_reg.ax) <<< 4);
            dy9_reg   <= uy8_reg - (WIDE_W'(side8_reg.ay) <<< 4);
            cx9_reg   <= cx9_next;
            cy9_reg   <= cy9_next;
            csat9_reg <= csat9_next;
            side9_reg <= side8_reg;

            ex10_reg         <= (dx9_reg < 0) ? WIDE_W'(-dx9_reg) : WIDE_W'(dx9_reg);
            ey10_reg         <= (dy9_reg < 0) ? WIDE_W'(-dy9_reg) : WIDE_W'(dy9_reg);
            side10_reg.tag   <= side9_reg.tag;
            side10_reg.cx    <= cx9_reg;
            side10_reg.cy    <= cy9_reg;
            side10_reg.gx    <= side9_reg.gx;
            side10_reg.gy    <= side9_reg.gy;
            side10_reg.degen <= side9_reg.degen;
            side10_reg.csat  <= csat9_reg;
            side10_reg.rsat  <= 1'b0;

            sqx11_reg  <= WIDE_W'(ex10_reg[31:0]) * WIDE_W'(ex10_reg[31:0]);
            sqy11_reg  <= WIDE_W'(ey10_reg[31:0]) * WIDE_W'(ey10_reg[31:0]);
            big11_reg  <= (|ex10_reg[WIDE_W-1:32]) || (|ey10_reg[WIDE_W-1:32]);
            side11_reg <= side10_reg;

            d12_reg          <= dsum[SQRT_IN_W-1:0];
            side12_reg.tag   <= side11_reg.tag;
            side12_reg.cx    <= side11_reg.cx;
            side12_reg.cy    <= side11_reg.cy;
            side12_reg.gx    <= side11_reg.gx;
            side12_reg.gy    <= side11_reg.gy;
            side12_reg.degen <= side11_reg.degen;
            side12_reg.csat  <= side11_reg.csat;
            side12_reg.rsat  <= big11_reg || dsum[SQRT_IN_W];

            tag_o_reg   <= sq_side.tag;
            degen_o_reg <= sq_side.degen;
            if (sq_side.degen)
            begin
                cx_o_reg  <= '0;
                cy_o_reg  <= '0;
                rad_o_reg <= '0;
                gx_o_reg  <= '0;
                gy_o_reg  <= '0;
                sat_o_reg <= 1'b0;
            end
            else
            begin
                cx_o_reg  <= sq_side.cx;
                cy_o_reg  <= sq_side.cy;
                rad_o_reg <= sq_side.rsat ? RAD_MAX : sq_root;
                gx_o_reg  <= sq_side.gx;
                gy_o_reg  <= sq_side.gy;
                sat_o_reg <= sq_side.csat || sq_side.rsat;
            end
        end
    end

    tcc_div_pipe #(
        .QW  (QW),
        .DVW (DVW),
        .SW  ($bits(div_side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .num_x     (mx7_reg),
        .num_y     (my7_reg),
        .den       (den7_reg),
        .side_in   (side7_reg),
        .out_valid (dv_valid),
        .quo_x     (quo_x),
        .quo_y     (quo_y),
        .side_out  (dv_side)
    );

    tcc_sqrt_pipe #(
        .SW ($bits(sqrt_side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v12_reg),
        .value     (d12_reg),
        .side_in   (side12_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    assign res_out.valid      = out_v_reg;
    assign res_out.tag_out    = tag_o_reg;
    assign res_out.center_x   = cx_o_reg;
    assign res_out.center_y   = cy_o_reg;
    assign res_out.radius     = rad_o_reg;
    assign res_out.centroid_x = gx_o_reg;
    assign res_out.centroid_y = gy_o_reg;
    assign res_out.degenerate = degen_o_reg;
    assign res_out.saturated  = sat_o_reg;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && res_out.degenerate |->
            res_out.radius == '0 && res_out.center_x == '0 && res_out.center_y == '0
            && !res_out.saturated)
        else $error("degenerate result carries nonzero fields");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && !res_out.ready |-> !tri_in.ready)
        else $error("input taken while result stalled");

    a_sat_cause: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && res_out.saturated |->
            res_out.radius == RAD_MAX || res_out.center_x == CTR_MAX
            || res_out.center_x == CTR_MIN || res_out.center_y == CTR_MAX
            || res_out.center_y == CTR_MIN)
        else $error("saturated flag without a clipped field");

endmodule

// File: rtl/tcc_div_pipe.sv
// pipelined restoring divider, two numerators over one shared divisor, one bit per stage
`timescale 1ns / 1ps
module tcc_div_pipe #(
    parameter int QW  = 44,
    parameter int DVW = 28,
    parameter int SW  = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [QW-1:0]  num_x,
    input  logic [QW-1:0]  num_y,
    input  logic [DVW-1:0] den,
    input  logic [SW-1:0]  side_in,
    output logic           out_valid,
    output logic [QW-1:0]  quo_x,
    output logic [QW-1:0]  quo_y,
    output logic [SW-1:0]  side_out
);

    logic           v_reg    [QW];
    logic [QW-1:0]  nx_reg   [QW];
    logic [QW-1:0]  ny_reg   [QW];
    logic [QW-1:0]  qx_reg   [QW];
    logic [QW-1:0]  qy_reg   [QW];
    logic [DVW-1:0] rx_reg   [QW];
    logic [DVW-1:0] ry_reg   [QW];
    logic [DVW-1:0] den_reg  [QW];
    logic [SW-1:0]  side_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic           v_in;
        logic [QW-1:0]  nx_in, ny_in, qx_in, qy_in;
        logic [DVW-1:0] rx_in, ry_in, den_in;
        logic [SW-1:0]  side_in_s;
        logic [DVW:0]   shx, shy;
        logic [DVW-1:0] rx_next, ry_next;
        logic           bx_next, by_next;

        if (i == 0) begin : g_first
            assign v_in      = in_valid;
            assign nx_in     = num_x;
            assign ny_in     = num_y;
            assign qx_in     = '0;
            assign qy_in     = '0;
            assign rx_in     = '0;
            assign ry_in     = '0;
            assign den_in    = den;
            assign side_in_s = side_in;
        end else begin : g_next
            assign v_in      = v_reg[i-1];
            assign nx_in     = nx_reg[i-1];
            assign ny_in     = ny_reg[i-1];
            assign qx_in     = qx_reg[i-1];
            assign qy_in     = qy_reg[i-1];
            assign rx_in     = rx_reg[i-1];
            assign ry_in     = ry_reg[i-1];
            assign den_in    = den_reg[i-1];
            assign side_in_s = side_reg[i-1];
        end

        always_comb
        begin
            shx     = {rx_in, nx_in[QW-1-i]};
            shy     = {ry_in, ny_in[QW-1-i]};
            bx_next = (shx >= {1'b0, den_in});
            by_next = (shy >= {1'b0, den_in});
            rx_next = bx_next ? DVW'(shx - {1'b0, den_in}) : shx[DVW-1:0];
            ry_next = by_next ? DVW'(shy - {1'b0, den_in}) : shy[DVW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nx_reg[i]   <= nx_in;
                ny_reg[i]   <= ny_in;
                qx_reg[i]   <= {qx_in[QW-2:0], bx_next};
                qy_reg[i]   <= {qy_in[QW-2:0], by_next};
                rx_reg[i]   <= rx_next;
                ry_reg[i]   <= ry_next;
                den_reg[i]  <= den_in;
                side_reg[i] <= side_in_s;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quo_x     = qx_reg[QW-1];
    assign quo_y     = qy_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

// File: rtl/tcc_sqrt_pipe.sv
// pipelined integer square root of a 64-bit value, one root bit per stage
`timescale 1ns / 1ps
module tcc_sqrt_pipe #(
    parameter int SW = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [tcc_pkg::SQRT_IN_W-1:0]  value,
    input  logic [SW-1:0]                  side_in,
    output logic                           out_valid,
    output logic [tcc_pkg::RAD_W-1:0]      root,
    output logic [SW-1:0]                  side_out
);
    import tcc_pkg::*;

    localparam int NST = SQRT_IN_W / 2;
    localparam int RTW = SQRT_IN_W / 2;
    localparam int RMW = RTW + 2;

    logic                 v_reg    [NST];
    logic [SQRT_IN_W-1:0] n_reg    [NST];
    logic [RMW-1:0]       rem_reg  [NST];
    logic [RTW-1:0]       root_reg [NST];
    logic [SW-1:0]        side_reg [NST];

    for (genvar k = 0; k < NST; k++) begin : g_stage
        logic                 v_in;
        logic [SQRT_IN_W-1:0] n_in;
        logic [RMW-1:0]       rem_in, rem_sh, trial, rem_next;
        logic [RTW-1:0]       root_in, root_next;
        logic [SW-1:0]        side_in_s;

        if (k == 0) begin : g_first
            assign v_in      = in_valid;
            assign n_in      = value;
            assign rem_in    = '0;
            assign root_in   = '0;
            assign side_in_s = side_in;
        end else begin : g_next
            assign v_in      = v_reg[k-1];
            assign n_in      = n_reg[k-1];
            assign rem_in    = rem_reg[k-1];
            assign root_in   = root_reg[k-1];
            assign side_in_s = side_reg[k-1];
        end

        always_comb
        begin
            rem_sh = {rem_in[RTW-1:0], n_in[SQRT_IN_W-1-2*k -: 2]};
            trial  = {root_in, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[RTW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_in[RTW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k]    <= n_in;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_in_s;
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign root      = RAD_W'(root_reg[NST-1]);
    assign side_out  = side_reg[NST-1];

endmodule

// File: dv/testbench.sv
// self-checking testbench for the triangle circumcircle core
`timescale 1ns / 1ps
module testbench;
    import tcc_pkg::*;

    localparam int CB         = COORD_BITS_DEF;
    localparam int LATENCY    = 3 * CB + 53;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_LEN   = 400;
    localparam int CMAX       = (1 << (CB - 1)) - 1;
    localparam int CMIN       = -(1 << (CB - 1));

    typedef struct {
        logic [TAG_W-1:0]     tag;
        logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
    } triangle_t;

    typedef struct {
        logic [TAG_W-1:0]        tag;
        logic signed [CTR_W-1:0] center_x, center_y;
        logic [RAD_W-1:0]        radius;
        logic signed [GC_W-1:0]  centroid_x, centroid_y;
        logic                    degenerate, saturated;
    } circle_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   idle_cycles;
    bit   hold_req;
    circle_t pending_circles[$];

    tcc_in_if  tri_ch();
    tcc_out_if res_ch();

    triangle_circumcircle_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .tri_in  (tri_ch),
        .res_out (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint round_div(longint num, longint den);
        longint unsigned mag, q;
        if (den < 0)
        begin
            num = -num;
            den = -den;
        end
        mag = (num < 0) ? longint'(-num) : num;
        q = (2 * mag + longint'(den)) / (2 * longint'(den));
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned acc, bitv;
        acc = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= acc + bitv)
            begin
                n = n - (acc + bitv);
                acc = (acc >> 1) + bitv;
            end
            else
                acc = acc >> 1;
            bitv = bitv >> 2;
        end
        return acc;
    endfunction

    function automatic longint clip_to(longint v, longint lo, longint hi, ref bit hit);
        if (v > hi)
        begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic circle_t predict_circle(triangle_t t);
        circle_t res;
        longint a_x, a_y, b_x, b_y, c_x, c_y, na, nb, nc, p, q, r, ux, uy, dx, dy;
        longint unsigned ex, ey, sx, sy, rad;
        bit sat, unused;
        a_x = t.ax; a_y = t.ay; b_x = t.bx; b_y = t.by; c_x = t.cx; c_y = t.cy;
        sat = 0;
        unused = 0;
        res = '{tag: t.tag, default: '0};
        r = (b_x - a_x) * (c_y - a_y) - (b_y - a_y) * (c_x - a_x);
        if (r == 0)
        begin
            res.degenerate = 1'b1;
            return res;
        end
        na = a_x * a_x + a_y * a_y;
        nb = b_x * b_x + b_y * b_y;
        nc = c_x * c_x + c_y * c_y;
        p = (b_y - a_y) * (nc - na) - (nb - na) * (c_y - a_y);
        q = -((b_x - a_x) * (nc - na) - (nb - na) * (c_x - a_x));
        ux = round_div(-8 * p, r);
        uy = round_div(-8 * q, r);
        dx = ux - 16 * a_x;
        dy = uy - 16 * a_y;
        ex = (dx < 0) ? -dx : dx;
        ey = (dy < 0) ? -dy : dy;
        if (ex > 64'hFFFF_FFFF || ey > 64'hFFFF_FFFF)
        begin
            rad = RAD_MAX;
            sat = 1'b1;
        end
        else
        begin
            sx = ex * ex;
            sy = ey * ey;
            if (sx > 64'hFFFF_FFFF_FFFF_FFFF - sy)
            begin
                rad = RAD_MAX;
                sat = 1'b1;
            end
            else
                rad = int_sqrt(sx + sy);
        end
        ux = clip_to(ux, CTR_MIN, CTR_MAX, sat);
        uy = clip_to(uy, CTR_MIN, CTR_MAX, sat);
        res.center_x   = ux[CTR_W-1:0];
        res.center_y   = uy[CTR_W-1:0];
        res.radius     = rad[RAD_W-1:0];
        res.centroid_x = GC_W'(clip_to((16 * (a_x + b_x + c_x)) / 3, GC_MIN, GC_MAX, unused));
        res.centroid_y = GC_W'(clip_to((16 * (a_y + b_y + c_y)) / 3, GC_MIN, GC_MAX, unused));
        res.saturated  = sat;
        return res;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        circle_t got, exp_c;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = '{res_ch.tag_out, res_ch.center_x, res_ch.center_y, res_ch.radius,
                    res_ch.centroid_x, res_ch.centroid_y, res_ch.degenerate,
                    res_ch.saturated};
            if (pending_circles.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result tag %0d", $time, got.tag);
            end
            else
            begin
                exp_c = pending_circles.pop_front();
                if (got.tag !== exp_c.tag || got.center_x !== exp_c.center_x
                    || got.center_y !== exp_c.center_y || got.radius !== exp_c.radius
                    || got.centroid_x !== exp_c.centroid_x
                    || got.centroid_y !== exp_c.centroid_y
                    || got.degenerate !== exp_c.degenerate
                    || got.saturated !== exp_c.saturated)
                begin
                    errors++;
                    $display("%0t: mismatch expected tag %0d c %0d,%0d r %0d g %0d,%0d d %b s %b",
                             $time, exp_c.tag, exp_c.center_x, exp_c.center_y,
                             exp_c.radius, exp_c.centroid_x, exp_c.centroid_y,
                             exp_c.degenerate, exp_c.saturated);
                    $display("%0t:          actual   tag %0d c %0d,%0d r %0d g %0d,%0d d %b s %b",
                             $time, got.tag, got.center_x, got.center_y, got.radius,
                             got.centroid_x, got.centroid_y, got.degenerate,
                             got.saturated);
                end
            end
        end
    end

    // result side flow control
    initial
    begin
        int pick;
        res_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            pick = $urandom_range(0, 99);
            if (hold_req)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (pick < 5)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(15, 60)) @(posedge clk);
            end
            else if (pick < 35)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 25)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((tri_ch.valid && tri_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_triangle(triangle_t t);
        tri_ch.triangle_tag <= t.tag;
        tri_ch.ax       <= t.ax;
        tri_ch.ay       <= t.ay;
        tri_ch.bx       <= t.bx;
        tri_ch.by_coord <= t.by;
        tri_ch.cx       <= t.cx;
        tri_ch.cy       <= t.cy;
        tri_ch.valid    <= 1'b1;
        @(posedge clk);
        while (!tri_ch.ready)
            @(posedge clk);
        pending_circles = {pending_circles, predict_circle(t)};
    endtask

    task automatic send_gap(int n);
        tri_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            send_gap($urandom_range(10, 40));
        else if (pick < 40)
            send_gap($urandom_range(1, 3));
    endtask

    task automatic send_coords(int a_x, int a_y, int b_x, int b_y, int c_x, int c_y);
        triangle_t t;
        t = '{TAG_W'($urandom_range(0, 65535)), CB'(a_x), CB'(a_y), CB'(b_x), CB'(b_y),
              CB'(c_x), CB'(c_y)};
        send_triangle(t);
    endtask

    function automatic int clamp_coord(int v);
        return (v > CMAX) ? CMAX : (v < CMIN) ? CMIN : v;
    endfunction

    function automatic triangle_t random_triangle();
        triangle_t t;
        int pick, span, a_x, a_y, b_x, b_y;
        pick = $urandom_range(0, 99);
        t.tag = TAG_W'($urandom_range(0, 65535));
        if (pick < 55)
        begin
            t.ax = CB'($urandom); t.ay = CB'($urandom); t.bx = CB'($urandom);
            t.by = CB'($urandom); t.cx = CB'($urandom); t.cy = CB'($urandom);
        end
        else if (pick < 80)
        begin
            span = $urandom_range(1, 8);
            t.ax = CB'(int'($urandom_range(0, 2 * span)) - span);
            t.ay = CB'(int'($urandom_range(0, 2 * span)) - span);
            t.bx = CB'(int'($urandom_range(0, 2 * span)) - span);
            t.by = CB'(int'($urandom_range(0, 2 * span)) - span);
            t.cx = CB'(int'($urandom_range(0, 2 * span)) - span);
            t.cy = CB'(int'($urandom_range(0, 2 * span)) - span);
        end
        else
        begin
            // nearly collinear: third vertex close to the midpoint
            a_x = $signed(CB'($urandom)); a_y = $signed(CB'($urandom));
            b_x = $signed(CB'($urandom)); b_y = $signed(CB'($urandom));
            t.ax = CB'(a_x); t.ay = CB'(a_y); t.bx = CB'(b_x); t.by = CB'(b_y);
            t.cx = CB'(clamp_coord((a_x + b_x) / 2 + int'($urandom_range(0, 2)) - 1));
            t.cy = CB'(clamp_coord((a_y + b_y) / 2 + int'($urandom_range(0, 2)) - 1));
        end
        return t;
    endfunction

    task automatic wait_drained();
        tri_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_circles.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_coords(0, 0, 1, 0, 0, 1);
        send_coords(0, 0, 2, 0, 0, 2);
        send_coords(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX);
        send_coords(CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
        send_coords(CMIN, CMAX, CMAX, CMAX, CMIN, CMIN);
        send_coords(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
        send_coords(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        send_coords(CMIN, CMIN, 0, 0, CMAX - 1, CMAX - 1);
        send_coords(5, 7, 5, 7, -3, 2);
        send_coords(CMIN, CMIN, CMAX, CMAX, CMAX, CMAX - 1);
        send_coords(CMIN, CMIN, CMAX, CMAX - 1, CMAX - 1, CMAX - 2);
        send_coords(CMIN, 0, CMAX, 1, 0, 0);
        send_coords(0, 0, 3, 0, 0, 1);
        send_coords(1, 0, 0, 1, -1, 0);
        send_coords(0, 0, 1, 1, 3, 0);
        send_coords(-1, -1, -2, 0, 0, -2);
        send_coords(CMAX, 0, 0, CMAX, CMAX, CMAX);
        send_coords(CMIN, 0, 0, CMIN, CMIN, CMIN);
        send_coords(0, 0, 0, 0, 1, 2);
        send_coords(-5, 3, 7, -2, 1, 9);
        send_triangle('{16'hFFFF, 0, 0, 1, 0, 0, 1});
        send_triangle('{16'h0000, 0, 0, 1, 0, 0, 1});
        wait_drained();
    endtask

    task automatic test_random(int count);
        repeat (count)
        begin
            send_triangle(random_triangle());
            random_gap();
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (150)
            send_triangle(random_triangle());
        wait_drained();
    endtask

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        tri_ch.valid = 1'b0;
        tri_ch.triangle_tag = '0;
        tri_ch.ax = '0; tri_ch.ay = '0; tri_ch.bx = '0;
        tri_ch.by_coord = '0; tri_ch.cx = '0; tri_ch.cy = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(300);
        wait_drained();
        test_backpressure();
        test_random(250);
        wait_drained();
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
